[rtl/snv_pkg.sv]
// Shared constants and types for the stereographic vector normaliser.
`timescale 1ns / 1ps
package snv_pkg;

  // Fixed-point format of features and results
  localparam int FracBits = 12;
  localparam int DataW    = 16;
  localparam int MagW     = 16;
  localparam int CfgW     = 16;
  localparam logic [CfgW-1:0] RadiusReset = CfgW'(1 << FracBits);

  // Element count: four plain features plus the extra coordinate
  localparam int Lanes = 5;
  localparam int FeatLanes = 4;

  // Internal widths: square, sum of squares, k = 4*r*r, denominator
  localparam int SqW  = 2 * MagW;
  localparam int SW   = SqW + 1;
  localparam int KW   = 2 * CfgW + 2;
  localparam int DenW = KW + 1;
  localparam int NumW = (DenW + FracBits > KW + MagW) ? DenW + FracBits : KW + MagW;

  // Divider: 16 quotient bits, one per stage, plus the loading stage
  localparam int QW     = 16;
  localparam int RW     = NumW + 2;
  localparam int LaneSt = QW + 1;

  // Front end stages and total register stages up to the output register
  localparam int FrontSt = 3;
  localparam int NStages = FrontSt + LaneSt + 1;

  // Saturation limits of the signed result magnitude
  localparam logic [QW-1:0] PosLimit = QW'(32767);
  localparam logic [QW-1:0] NegLimit = QW'(32768);

  // Per-lane sideband carried alongside the divider data
  typedef struct packed {
    logic neg;
    logic zero;
  } snv_side_t;

endpackage

[rtl/stereographic_vector_normalizer.sv]
// A vector passes through the front-end stages, the lane divider stages and the output register.
// Throughput: one vector per cycle when not stalled; lane dividers: load + 16 bit stages.
// A stall reaches the input only when every stage is full; empty stages still take vectors.
// Reset clears the stage valid bits and sets the radius to 1.0 (no clearing pass).
// Top level: radius register, valid chain, five lanes and the merging output stage.
`timescale 1ns / 1ps
module stereographic_vector_normalizer import snv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgW-1:0]         cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DataW-1:0] feature_0_i,
  input  logic signed [DataW-1:0] feature_1_i,
  input  logic signed [DataW-1:0] feature_2_i,
  input  logic signed [DataW-1:0] feature_3_i,
  input  logic signed [DataW-1:0] feature_4_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] projected_0_o,
  output logic signed [DataW-1:0] projected_1_o,
  output logic signed [DataW-1:0] projected_2_o,
  output logic signed [DataW-1:0] projected_3_o,
  output logic signed [DataW-1:0] projected_extra_o,
  output logic                    zero_denominator_o
);

  logic [CfgW-1:0]        r_q;
  logic [KW-1:0]          k_q;
  logic [2*CfgW-1:0]      rr;
  logic [NStages-1:0]     v_q;
  logic [NStages-1:0]     v_d;
  logic [NStages-1:0]     ready;
  logic signed [DataW-1:0] feat [Lanes];
  logic [NumW-1:0]        num  [Lanes];
  logic [DenW-1:0]        den;
  snv_side_t              side [Lanes];
  logic [QW-1:0]          quo  [Lanes];
  logic                   ovf  [Lanes];
  snv_side_t              lside [Lanes];
  logic [DataW-1:0]       res_d [Lanes];
  logic [DataW-1:0]       res_q [Lanes];
  logic                   zero_q;

  // Radius register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= RadiusReset;
    end else if (cfg_we_i) begin
      r_q <= cfg_wdata_i;
    end
  end

  // k = 4*r*r, refreshed every cycle
  assign rr = r_q * r_q;
  always_ff @(posedge clk_i) begin
    k_q <= {rr, 2'b00};
  end

  // Valid chain: a stage loads when empty or when its contents move on
  always_comb begin
    ready[NStages-1] = !v_q[NStages-1] || !out_stall_i;
    for (int i = NStages - 2; i >= 0; i--) begin
      ready[i] = !v_q[i] || ready[i+1];
    end
    v_d[0] = ready[0] ? in_valid_i : v_q[0];
    for (int i = 1; i < NStages; i++) begin
      v_d[i] = ready[i] ? v_q[i-1] : v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o = !ready[0];

  assign feat[0] = feature_0_i;
  assign feat[1] = feature_1_i;
  assign feat[2] = feature_2_i;
  assign feat[3] = feature_3_i;
  assign feat[4] = feature_4_i;

  snv_front u_front (
    .clk_i  (clk_i),
    .en_i   (ready[FrontSt-1:0]),
    .k_i    (k_q),
    .feat_i (feat),
    .num_o  (num),
    .den_o  (den),
    .side_o (side)
  );

  // Five divider lanes side by side
  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    snv_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (ready[FrontSt+LaneSt-1:FrontSt]),
      .num_i  (num[l]),
      .den_i  (den),
      .side_i (side[l]),
      .quo_o  (quo[l]),
      .ovf_o  (ovf[l]),
      .side_o (lside[l])
    );
  end

  // Merge: saturate, apply sign, force zero on an empty denominator
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      logic [QW-1:0] lim;
      logic [QW-1:0] m;
      lim = lside[l].neg ? NegLimit : PosLimit;
      m   = (ovf[l] || quo[l] > lim) ? lim : quo[l];
      if (lside[l].zero) begin
        res_d[l] = '0;
      end else begin
        res_d[l] = lside[l].neg ? DataW'(~m + 1'b1) : DataW'(m);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[NStages-1]) begin
      for (int l = 0; l < Lanes; l++) begin
        res_q[l] <= res_d[l];
      end
      zero_q <= lside[0].zero;
    end
  end

  assign out_valid_o        = v_q[NStages-1];
  assign projected_0_o      = res_q[0];
  assign projected_1_o      = res_q[1];
  assign projected_2_o      = res_q[2];
  assign projected_3_o      = res_q[3];
  assign projected_extra_o  = res_q[4];
  assign zero_denominator_o = zero_q;

  // An empty output register never holds back the input
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NStages-1] |-> !in_stall_o)
    else $error("input stalled while output register empty");

  // An input transfer always lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v_q[0])
    else $error("accepted vector lost at first stage");

  // A zero denominator gives all-zero results
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_denominator_o |-> projected_0_o == '0 && projected_1_o == '0 &&
      projected_2_o == '0 && projected_3_o == '0 && projected_extra_o == '0)
    else $error("nonzero result with zero denominator");

  // A stalled result stays valid
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

[rtl/snv_front.sv]
// Front end: squares, sum of squares, numerators and the shared denominator.
`timescale 1ns / 1ps
module snv_front import snv_pkg::*; (
  input  logic                   clk_i,
  input  logic [FrontSt-1:0]     en_i,
  input  logic [KW-1:0]          k_i,
  input  logic signed [DataW-1:0] feat_i [Lanes],
  output logic [NumW-1:0]        num_o  [Lanes],
  output logic [DenW-1:0]        den_o,
  output snv_side_t              side_o [Lanes]
);

  logic [MagW-1:0]         mag_d  [Lanes];
  logic [MagW-1:0]         mag_q  [Lanes];
  logic [SqW-1:0]          sq_q   [Lanes];
  logic [Lanes-1:0]        neg1_q;
  logic [SW-1:0]           s_q;
  logic [KW+MagW-1:0]      prod_q [FeatLanes];
  logic [FeatLanes-1:0]    neg2_q;
  logic [DenW-1:0]         den_d;
  logic [DenW-1:0]         diff_d;
  logic                    ge_d;
  logic [NumW-1:0]         num_q  [Lanes];
  logic [DenW-1:0]         den_q;
  logic [Lanes-1:0]        neg3_q;
  logic                    zero_q;

  // Magnitudes of the signed features
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      mag_d[i] = feat_i[i][DataW-1] ? MagW'(~feat_i[i] + 1'b1) : MagW'(feat_i[i]);
    end
  end

  // Stage 1: squares
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < Lanes; i++) begin
        mag_q[i]  <= mag_d[i];
        sq_q[i]   <= SqW'(mag_d[i]) * SqW'(mag_d[i]);
        neg1_q[i] <= feat_i[i][DataW-1];
      end
    end
  end

  // Stage 2: sum of squares and k*|x| products
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s_q <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]) + SW'(sq_q[3]) + SW'(sq_q[4]);
      for (int i = 0; i < FeatLanes; i++) begin
        prod_q[i] <= k_i * mag_q[i];
      end
      neg2_q <= neg1_q[FeatLanes-1:0];
    end
  end

  // Denominator and |s - k|
  always_comb begin
    den_d  = DenW'(k_i) + DenW'(s_q);
    ge_d   = DenW'(s_q) >= DenW'(k_i);
    diff_d = ge_d ? DenW'(s_q) - DenW'(k_i) : DenW'(k_i) - DenW'(s_q);
  end

  // Stage 3: numerators ready for the dividers
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int i = 0; i < FeatLanes; i++) begin
        num_q[i]  <= NumW'(prod_q[i]);
        neg3_q[i] <= neg2_q[i];
      end
      num_q[FeatLanes]  <= NumW'(diff_d) << FracBits;
      neg3_q[FeatLanes] <= !ge_d;
      den_q             <= den_d;
      zero_q            <= (den_d == '0);
    end
  end

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      num_o[i]       = num_q[i];
      side_o[i].neg  = neg3_q[i];
      side_o[i].zero = zero_q;
    end
    den_o = den_q;
  end

endmodule

[rtl/snv_lane.sv]
// One divider lane: rounded quotient, one bit per pipeline stage after the load stage.
`timescale 1ns / 1ps
module snv_lane import snv_pkg::*; (
  input  logic              clk_i,
  input  logic [LaneSt-1:0] en_i,
  input  logic [NumW-1:0]   num_i,
  input  logic [DenW-1:0]   den_i,
  input  snv_side_t         side_i,
  output logic [QW-1:0]     quo_o,
  output logic              ovf_o,
  output snv_side_t         side_o
);

  logic [RW-1:0]   rem_q  [LaneSt];
  logic [RW-1:0]   div_q  [LaneSt];
  logic [QW-1:0]   quo_q  [LaneSt];
  logic            ovf_q  [LaneSt];
  snv_side_t       side_q [LaneSt];

  // Load: rounding folded in as (2n + d) / (2d)
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0]  <= (RW'(num_i) << 1) + RW'(den_i);
      div_q[0]  <= RW'(den_i) << 1;
      quo_q[0]  <= '0;
      ovf_q[0]  <= 1'b0;
      side_q[0] <= side_i;
    end
  end

  // Restoring steps, most significant quotient bit first
  for (genvar j = 1; j < LaneSt; j++) begin : g_step
    localparam int B = QW - j;
    logic [RW-1:0] shifted;
    logic [RW:0]   trial;
    logic          take;
    logic          ovf_d;

    always_comb begin
      shifted = div_q[j-1] << B;
      trial   = {1'b0, rem_q[j-1]} - {1'b0, shifted};
      take    = !trial[RW];
    end

    // Quotient of 2^16 or more saturates in any case
    if (j == 1) begin : g_ovf
      assign ovf_d = rem_q[0] >= (div_q[0] << QW);
    end else begin : g_noovf
      assign ovf_d = ovf_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j]  <= take ? trial[RW-1:0] : rem_q[j-1];
        div_q[j]  <= div_q[j-1];
        quo_q[j]  <= {quo_q[j-1][QW-2:0], take};
        ovf_q[j]  <= ovf_d;
        side_q[j] <= side_q[j-1];
      end
    end
  end

  assign quo_o  = quo_q[LaneSt-1];
  assign ovf_o  = ovf_q[LaneSt-1];
  assign side_o = side_q[LaneSt-1];

endmodule
